// ----- rtl/gtcf_pkg.sv -----
`timescale 1ns / 1ps
// shared types, frame constants and crc helper for the gimbal track command framer
package gtcf_pkg;

   // coordinate and register width
   localparam int COORD_WIDTH = 12;

   // default depth of the command queue between front and back
   localparam int GTCF_QUEUE_DEPTH = 4;

   // register reset values
   localparam logic [COORD_WIDTH-1:0] CENTER_X_RESET = COORD_WIDTH'(960);
   localparam logic [COORD_WIDTH-1:0] CENTER_Y_RESET = COORD_WIDTH'(540);

   // register indexes
   localparam logic CSR_CENTER_X = 1'b0;
   localparam logic CSR_CENTER_Y = 1'b1;

   // dead zone: DEAD_DEN * |d| <= DEAD_NUM * center
   localparam int DEAD_NUM = 3;
   localparam int DEAD_DEN = 10;

   // doubled angle gains, magnitude k reached when gain2 * |d| >= (2k-1) * center
   localparam int GAIN_X2 = 270;
   localparam int GAIN_Y2 = 50;
   localparam int LIMIT_DEG = 5;
   localparam int ANGLE_SCALE = 10;

   // frame layout
   localparam int FRAME_LEN = 14;
   localparam int HEADER_LEN = 8;
   localparam int IDX_WIDTH = $clog2(FRAME_LEN);
   localparam logic [IDX_WIDTH-1:0] BYTE_YAW_LO = IDX_WIDTH'(8);
   localparam logic [IDX_WIDTH-1:0] BYTE_YAW_HI = IDX_WIDTH'(9);
   localparam logic [IDX_WIDTH-1:0] BYTE_PITCH_LO = IDX_WIDTH'(10);
   localparam logic [IDX_WIDTH-1:0] BYTE_PITCH_HI = IDX_WIDTH'(11);
   localparam logic [IDX_WIDTH-1:0] BYTE_CRC_LO = IDX_WIDTH'(12);
   localparam logic [IDX_WIDTH-1:0] BYTE_CRC_HI = IDX_WIDTH'(13);
   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(FRAME_LEN - 1);

   localparam logic [7:0] FRAME_HEADER [0:HEADER_LEN-1] = '{
      8'h55, 8'h66, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h0E
   };

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // input item
   typedef struct packed {
      logic [COORD_WIDTH-1:0] pix_col;
      logic [COORD_WIDTH-1:0] pix_row;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } rsp_type;

   // classified command between front and back
   typedef struct packed {
      logic [15:0] yaw_val;
      logic [15:0] pitch_val;
   } cmd_type;

   // queue fill status
   typedef struct packed {
      logic empty;
      logic almost_full;
      logic full;
   } q_status_type;

   // one byte of crc-16, msb first, no reflection
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/gtcf_front.sv -----
`timescale 1ns / 1ps
// front end: accepts target items, measures offsets and classifies into commands
module gtcf_front import gtcf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_payload,
   input  logic [COORD_WIDTH-1:0] center_x,
   input  logic [COORD_WIDTH-1:0] center_y,
   input  q_status_type           q_status,
   output logic                   push,
   output cmd_type                push_cmd
);

   localparam int PW = COORD_WIDTH + 9;
   localparam int DW = COORD_WIDTH + 4;

   logic                   a_valid_ff, a_valid_in;
   logic [COORD_WIDTH-1:0] a_magx_ff, a_magx_in;
   logic [COORD_WIDTH-1:0] a_magy_ff, a_magy_in;
   logic                   a_negx_ff, a_negx_in;
   logic                   a_negy_ff, a_negy_in;
   logic [COORD_WIDTH:0]   dx, dy, ndx, ndy;
   logic                   accept;
   logic                   dead_x, dead_y;

   // signed angle times ten from a magnitude and its sign
   function automatic logic [15:0] angle_val(input logic [COORD_WIDTH-1:0] mag,
                                             input logic neg,
                                             input logic [COORD_WIDTH-1:0] ctr,
                                             input logic [8:0] gain2);
      logic [PW-1:0] prod;
      logic [2:0]    r;
      logic [15:0]   v;
      prod = PW'(gain2) * PW'(mag);
      r = 3'd0;
      for (int k = 1; k <= LIMIT_DEG; k++) begin
         if (prod >= PW'(2 * k - 1) * PW'(ctr)) begin
            r = r + 3'd1;
         end
      end
      if (mag == '0) begin
         r = 3'd0;
      end
      v = 16'(r) * 16'(ANGLE_SCALE);
      // positive offset turns the gimbal the other way
      if (!neg) begin
         v = -v;
      end
      return v;
   endfunction

   // accept while the queue keeps room for the item in flight
   assign busy = q_status.full || (q_status.almost_full && a_valid_ff);
   assign accept = start && !busy;

   // offsets from center, split into magnitude and sign
   always_comb begin
      dx = {1'b0, req_payload.pix_col} - {1'b0, center_x};
      dy = {1'b0, req_payload.pix_row} - {1'b0, center_y};
      ndx = -dx;
      ndy = -dy;
      a_valid_in = accept;
      a_negx_in = dx[COORD_WIDTH];
      a_negy_in = dy[COORD_WIDTH];
      a_magx_in = dx[COORD_WIDTH] ? ndx[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
      a_magy_in = dy[COORD_WIDTH] ? ndy[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];
   end

   // offset stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      a_magx_ff <= a_magx_in;
      a_magy_ff <= a_magy_in;
      a_negx_ff <= a_negx_in;
      a_negy_ff <= a_negy_in;
   end

   // dead zone test and angle thresholds
   always_comb begin
      dead_x = DW'(DEAD_DEN) * DW'(a_magx_ff) <= DW'(DEAD_NUM) * DW'(center_x);
      dead_y = DW'(DEAD_DEN) * DW'(a_magy_ff) <= DW'(DEAD_NUM) * DW'(center_y);
      push = a_valid_ff && !(dead_x && dead_y);
      push_cmd.yaw_val = angle_val(a_magx_ff, a_negx_ff, center_x, 9'(GAIN_X2));
      push_cmd.pitch_val = angle_val(a_magy_ff, a_negy_ff, center_y, 9'(GAIN_Y2));
   end

endmodule

// ----- rtl/gtcf_queue.sv -----
`timescale 1ns / 1ps
// short command queue between the front and back ends
module gtcf_queue import gtcf_pkg::*; #(
   parameter int QUEUE_DEPTH = GTCF_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   input  logic         pop,
   output cmd_type      head_cmd,
   output q_status_type q_status
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(QUEUE_DEPTH);
   localparam logic [CNT_WIDTH-1:0] CNT_ALMOST = CNT_WIDTH'(QUEUE_DEPTH - 1);

   cmd_type                mem_ff [0:QUEUE_DEPTH-1];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign do_push = push && (count_ff != CNT_FULL);
   assign do_pop = pop && (count_ff != '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd = mem_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full = (count_ff == CNT_FULL);
   assign q_status.almost_full = (count_ff == CNT_ALMOST);

   // the front pushes into a full queue only in a cycle that also pops
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && (count_ff == CNT_FULL) |-> pop)
      else $error("command pushed into full queue");

   // the back never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("command popped from empty queue");

   // fill count rises by one on a push without a pop
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost a push");

endmodule

// ----- rtl/gtcf_back.sv -----
`timescale 1ns / 1ps
// back end: serializes each command into a fourteen byte frame with crc
module gtcf_back import gtcf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  cmd_type      head_cmd,
   output logic         pop,
   output logic         rsp_strobe,
   output rsp_type      rsp_payload
);

   logic                 active_ff, active_in;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic [15:0]          yaw_ff, yaw_in;
   logic [15:0]          pitch_ff, pitch_in;
   logic [15:0]          crc_ff, crc_in;
   logic                 strobe_ff, strobe_in;
   rsp_type              out_ff, out_in;
   logic [7:0]           cur_byte;
   logic                 at_last;

   assign at_last = (idx_ff == LAST_IDX);

   // byte select for the current frame position
   always_comb begin
      priority if (idx_ff < IDX_WIDTH'(HEADER_LEN)) begin
         cur_byte = FRAME_HEADER[idx_ff[2:0]];
      end else if (idx_ff == BYTE_YAW_LO) begin
         cur_byte = yaw_ff[7:0];
      end else if (idx_ff == BYTE_YAW_HI) begin
         cur_byte = yaw_ff[15:8];
      end else if (idx_ff == BYTE_PITCH_LO) begin
         cur_byte = pitch_ff[7:0];
      end else if (idx_ff == BYTE_PITCH_HI) begin
         cur_byte = pitch_ff[15:8];
      end else if (idx_ff == BYTE_CRC_LO) begin
         cur_byte = crc_ff[7:0];
      end else begin
         cur_byte = crc_ff[15:8];
      end
   end

   // sequencer: next frame is taken on the last byte of the current one, or when idle
   always_comb begin
      pop = (!active_ff || at_last) && !q_status.empty;
      active_in = active_ff;
      idx_in = idx_ff;
      yaw_in = yaw_ff;
      pitch_in = pitch_ff;
      crc_in = crc_ff;
      strobe_in = active_ff;
      out_in.frame_byte = cur_byte;
      out_in.last_byte = at_last;
      if (active_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff < BYTE_CRC_LO) begin
            crc_in = crc16_byte(crc_ff, cur_byte);
         end
         if (at_last) begin
            active_in = 1'b0;
         end
      end
      if (pop) begin
         active_in = 1'b1;
         idx_in = '0;
         crc_in = '0;
         yaw_in = head_cmd.yaw_val;
         pitch_in = head_cmd.pitch_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
         idx_ff <= idx_in;
      end
      yaw_ff <= yaw_in;
      pitch_ff <= pitch_in;
      crc_ff <= crc_in;
      out_ff <= out_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_payload = out_ff;

   // the frame position never runs past the last byte
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> idx_ff <= LAST_IDX)
      else $error("frame position out of range");

   // last marker only after the final frame position
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.last_byte |-> $past(active_ff && at_last))
      else $error("last byte flagged at wrong position");

endmodule

// ----- rtl/gimbal_track_command_framer.sv -----
`timescale 1ns / 1ps
// top level of the gimbal track command framer
// a taken item passes the offset stage, command queue and sequencer before its bytes strobe
// the byte-wide serializer in the back end sends queued frames back to back;
// dead zone items drop out of the front end in the cycle after they are taken, with no bytes
// busy: queue full, or almost full with an item in flight; rsp_strobe cannot be stalled
// synchronous reset clears the queue, sequencer and strobe and loads the center registers
module gimbal_track_command_framer import gtcf_pkg::*; #(
   parameter int QUEUE_DEPTH = GTCF_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_payload,
   output logic                   rsp_strobe,
   output rsp_type                rsp_payload,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [COORD_WIDTH-1:0] csr_wdata
);

   logic [COORD_WIDTH-1:0] center_x_ff, center_x_in;
   logic [COORD_WIDTH-1:0] center_y_ff, center_y_in;
   logic                   push, pop;
   cmd_type                push_cmd, head_cmd;
   q_status_type           q_status;

   // center registers
   always_comb begin
      center_x_in = center_x_ff;
      center_y_in = center_y_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_in = csr_wdata;
            CSR_CENTER_Y: center_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= CENTER_X_RESET;
         center_y_ff <= CENTER_Y_RESET;
      end else begin
         center_x_ff <= center_x_in;
         center_y_ff <= center_y_in;
      end
   end

   gtcf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   gtcf_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   gtcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
